### hdl/dcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue package
// Shared sizes, codes and transfer types for the dual circular queue.
// ----------------------------------------------------------------------------
package dcq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_W      = SLOT_W + 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = 2 * QUEUE_DEPTH;
    localparam int DATA_W      = 32;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                     command;
        logic                     queue_select;
        logic signed [DATA_W-1:0] push_data;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_data;
        logic [1:0]               status;
    } out_item_t;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
    } dcq_op_t;

endpackage

### hdl/dcq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue front end
// Tracks head, tail and fill of both queues, classifies each transfer and
// issues a store operation with its status.
// ----------------------------------------------------------------------------
module dcq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dcq_pkg::in_item_t in_item,
    input  logic              link_full,
    output logic              full,
    output logic              op_valid,
    output dcq_pkg::dcq_op_t  op
);
    import dcq_pkg::*;

    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(STORE_DEPTH - 1);

    logic [SLOT_W-1:0] head_reg [2];
    logic [SLOT_W-1:0] head_next [2];
    logic [SLOT_W-1:0] tail_reg [2];
    logic [SLOT_W-1:0] tail_next [2];
    logic [CNT_W-1:0]  count_reg [2];
    logic [CNT_W-1:0]  count_next [2];

    logic              accept;
    logic              sel;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] new_tail;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = s + SLOT_W'(1);
        return r;
    endfunction

    assign full     = link_full;
    assign accept   = push & ~link_full;
    assign op_valid = accept;

    always_comb
    begin
        sel        = in_item.queue_select;
        cnt        = count_reg[sel];
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        slot       = '0;
        new_tail   = '0;
        op.wr      = 1'b0;
        op.rd      = 1'b0;
        op.data    = in_item.push_data;
        op.status  = STATUS_OK;
        if (in_item.command == CMD_PUSH)
        begin
            if (cnt == CNT_W'(QUEUE_DEPTH))
            begin
                op.status = STATUS_OVERFLOW;
            end
            else
            begin
                if (cnt == '0)
                begin
                    new_tail       = '0;
                    head_next[sel] = '0;
                end
                else
                begin
                    new_tail = next_slot(tail_reg[sel]);
                end
                tail_next[sel]  = new_tail;
                count_next[sel] = cnt + CNT_W'(1);
                slot            = new_tail;
                op.wr           = 1'b1;
            end
        end
        else
        begin
            if (cnt == '0)
            begin
                op.status = STATUS_UNDERFLOW;
            end
            else
            begin
                slot  = head_reg[sel];
                op.rd = 1'b1;
                if (cnt == CNT_W'(1))
                begin
                    head_next[sel] = '0;
                    tail_next[sel] = '0;
                end
                else
                begin
                    head_next[sel] = next_slot(head_reg[sel]);
                end
                count_next[sel] = cnt - CNT_W'(1);
            end
        end
        if (sel)
            op.addr = TOP_ADDR - {1'b0, slot};
        else
            op.addr = {1'b0, slot};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '{default: '0};
            tail_reg  <= '{default: '0};
            count_reg <= '{default: '0};
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/dcq_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue operation link
// Two-entry queue of store operations between front end and back end.
// ----------------------------------------------------------------------------
module dcq_link (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    input  dcq_pkg::dcq_op_t wr_op,
    output logic             full,
    output logic             rd_valid,
    output dcq_pkg::dcq_op_t rd_op,
    input  logic             rd_take
);
    import dcq_pkg::*;

    dcq_op_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid & ~full;
    assign do_rd    = rd_take & rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr & ~do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd & ~do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/dcq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue back end
// Carries out store writes and registered reads, and buffers results in a
// two-entry output queue.
// ----------------------------------------------------------------------------
module dcq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  dcq_pkg::dcq_op_t   op,
    output logic               op_take,
    output logic               empty,
    input  logic               pop,
    output dcq_pkg::out_item_t out_item
);
    import dcq_pkg::*;

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              s1_valid_reg;
    logic              s1_rd_reg;
    logic [1:0]        s1_status_reg;

    out_item_t  outq_reg [2];
    logic       outq_wr_ptr_reg;
    logic       outq_rd_ptr_reg;
    logic [1:0] outq_count_reg;
    logic [1:0] outq_count_next;
    logic [2:0] pending;
    logic       out_pop;
    out_item_t  s1_item;

    assign empty    = (outq_count_reg == 2'd0);
    assign out_pop  = pop & ~empty;
    assign out_item = outq_reg[outq_rd_ptr_reg];
    assign pending  = {1'b0, outq_count_reg} + {2'b00, s1_valid_reg};
    assign op_take  = op_valid & ((pending < 3'd2) | out_pop);

    assign s1_item.pop_data = s1_rd_reg ? rd_data_reg : '0;
    assign s1_item.status   = s1_status_reg;

    always_comb
    begin
        outq_count_next = outq_count_reg;
        if (s1_valid_reg & ~out_pop)
            outq_count_next = outq_count_reg + 2'd1;
        else if (out_pop & ~s1_valid_reg)
            outq_count_next = outq_count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (op_take & op.wr)
            store_mem[op.addr] <= op.data;
        if (op_take & op.rd)
            rd_data_reg <= store_mem[op.addr];
        if (op_take)
        begin
            s1_rd_reg     <= op.rd;
            s1_status_reg <= op.status;
        end
        if (s1_valid_reg)
            outq_reg[outq_wr_ptr_reg] <= s1_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            outq_wr_ptr_reg <= 1'b0;
            outq_rd_ptr_reg <= 1'b0;
            outq_count_reg  <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= op_take;
            if (s1_valid_reg)
                outq_wr_ptr_reg <= ~outq_wr_ptr_reg;
            if (out_pop)
                outq_rd_ptr_reg <= ~outq_rd_ptr_reg;
            outq_count_reg <= outq_count_next;
        end
    end

endmodule

### hdl/dual_circular_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue
// Two circular queues sharing one store: one upward from the bottom, one
// downward from the top. Each transfer is a push or pop with one result.
// Path: accepted items pass the link entry, store read stage and output queue.
// Throughput: one item per cycle (single store port) while results are popped.
// Reset: asynchronous, active low; both queues empty, store contents undefined.
// ----------------------------------------------------------------------------
module dual_circular_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  dcq_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output dcq_pkg::out_item_t out_item
);
    import dcq_pkg::*;

    logic    link_full;
    logic    fr_valid;
    dcq_op_t fr_op;
    logic    bk_valid;
    dcq_op_t bk_op;
    logic    bk_take;

    dcq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .link_full (link_full),
        .full      (full),
        .op_valid  (fr_valid),
        .op        (fr_op)
    );

    dcq_link u_link (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_op    (fr_op),
        .full     (link_full),
        .rd_valid (bk_valid),
        .rd_op    (bk_op),
        .rd_take  (bk_take)
    );

    dcq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (bk_valid),
        .op       (bk_op),
        .op_take  (bk_take),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

### verif/dcq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue checker
// Watches both transfer channels of the dual circular queue. Each accepted
// command updates a private copy of both queues and the shared store, and its
// predicted result is queued. Each accepted result is compared field by field
// with the oldest prediction. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module dcq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  dcq_pkg::in_item_t  in_item,
    input  logic               empty,
    input  logic               pop,
    input  dcq_pkg::out_item_t out_item,
    output int                 fail_count,
    output int                 pending
);
    import dcq_pkg::*;

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic [SLOT_W-1:0] head_slot [2];
    logic [SLOT_W-1:0] tail_slot [2];
    logic [CNT_W-1:0]  fill_level [2];

    out_item_t predicted_results [$];
    out_item_t want;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic int store_addr(input int q, input logic [SLOT_W-1:0] s);
        return (q != 0) ? STORE_DEPTH - 1 - int'(s) : int'(s);
    endfunction

    function automatic out_item_t apply_queue_op(input in_item_t it);
        out_item_t res;
        int        q;
        res.pop_data = '0;
        res.status   = STATUS_OK;
        q            = int'(it.queue_select);
        if (it.command == CMD_PUSH)
        begin
            if (fill_level[q] >= QUEUE_DEPTH)
                res.status = STATUS_OVERFLOW;
            else
            begin
                if (fill_level[q] == 0)
                begin
                    head_slot[q] = '0;
                    tail_slot[q] = '0;
                end
                else
                    tail_slot[q] = next_slot(tail_slot[q]);
                store_mem[store_addr(q, tail_slot[q])] = it.push_data;
                fill_level[q] = fill_level[q] + 1'b1;
            end
        end
        else
        begin
            if (fill_level[q] == 0)
                res.status = STATUS_UNDERFLOW;
            else
            begin
                res.pop_data = store_mem[store_addr(q, head_slot[q])];
                if (fill_level[q] == 1)
                begin
                    head_slot[q] = '0;
                    tail_slot[q] = '0;
                end
                else
                    head_slot[q] = next_slot(head_slot[q]);
                fill_level[q] = fill_level[q] - 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < 2; q++)
            begin
                head_slot[q]  = '0;
                tail_slot[q]  = '0;
                fill_level[q] = '0;
            end
            predicted_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: pop_data %0d, status %0d",
                           out_item.pop_data, out_item.status);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (out_item.pop_data !== want.pop_data)
                    begin
                        $error("pop_data: expected %0d, got %0d",
                               want.pop_data, out_item.pop_data);
                        fail_count++;
                    end
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, out_item.status);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                predicted_results.push_back(apply_queue_op(in_item));
            pending = predicted_results.size();
        end
    end

endmodule

### verif/tb_dual_circular_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual circular queue testbench
// Drives push and pop commands to both queues: a directed opening covering
// data extremes, underflow and ignored pop data, then random fill, drain and
// mixed sequences that run the queues into overflow and underflow and wrap
// them. The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_dual_circular_queue;
    import dcq_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 600000;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;
    int        fail_count;
    int        pending;

    int        burst_left = 0;
    int        items_sent = 0;
    int        cycles     = 0;

    dual_circular_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    dcq_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic sel, input logic [DATA_W-1:0] data);
        int       gap;
        in_item_t nxt;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        nxt.command      = cmd;
        nxt.queue_select = sel;
        nxt.push_data    = data;
        push    <= 1'b1;
        in_item <= nxt;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // hold off until every transfer has come back
    task automatic drain_all();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        int   seq_len;
        int   push_pct;
        logic fixed_sel;
        logic sel;
        logic cmd;
        bit   one_queue;

        rst_n   <= 1'b0;
        push    <= 1'b0;
        in_item <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_POP,  1'b0, 32'h0000_0000);
        send_item(CMD_POP,  1'b1, 32'hffff_ffff);
        send_item(CMD_PUSH, 1'b0, 32'h8000_0000);
        send_item(CMD_PUSH, 1'b0, 32'h7fff_ffff);
        send_item(CMD_PUSH, 1'b0, 32'h0000_0000);
        send_item(CMD_PUSH, 1'b0, 32'hffff_ffff);
        send_item(CMD_PUSH, 1'b1, 32'hffff_ffff);
        send_item(CMD_PUSH, 1'b1, 32'h0000_0000);
        send_item(CMD_PUSH, 1'b1, 32'h7fff_ffff);
        send_item(CMD_PUSH, 1'b1, 32'h8000_0000);
        send_item(CMD_POP,  1'b1, 32'h5a5a_a5a5);
        send_item(CMD_POP,  1'b0, 32'ha5a5_5a5a);
        send_item(CMD_POP,  1'b0, 32'hffff_ffff);
        send_item(CMD_POP,  1'b0, 32'h0000_0000);
        send_item(CMD_POP,  1'b0, 32'h1234_5678);
        send_item(CMD_POP,  1'b0, 32'h0000_0000);
        send_item(CMD_PUSH, 1'b0, 32'h0bad_cafe);
        send_item(CMD_POP,  1'b1, 32'h0000_0000);
        send_item(CMD_POP,  1'b1, 32'h0000_0000);
        send_item(CMD_POP,  1'b1, 32'h0000_0000);
        send_item(CMD_POP,  1'b1, 32'h0000_0000);
        send_item(CMD_POP,  1'b0, 32'h0000_0000);
        drain_all();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            seq_len   = $urandom_range(8, 160);
            one_queue = ($urandom_range(0, 9) < 7);
            fixed_sel = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       push_pct = 85;
                1:       push_pct = 15;
                2:       push_pct = 50;
                default: push_pct = $urandom_range(0, 100);
            endcase
            for (int i = 0; i < seq_len; i++)
            begin
                sel = one_queue ? fixed_sel : 1'($urandom_range(0, 1));
                cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                send_item(cmd, sel, pick_data());
                if (items_sent % 700 == 0)
                    drain_all();
            end
        end

        drain_all();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int mode;
        int run_len;
        pop <= 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(1, 60);
            for (int i = 0; i < run_len; i++)
            begin
                @(posedge clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 3) != 0);
                    default: pop <= ((i % 4) != 3);
                endcase
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
